### design/vma_pkg.sv
// ----------------------------------------------------------------------------
// Vector mean accumulator package
// Shared widths, limits, action codes and sequencer states.
// ----------------------------------------------------------------------------
package vma_pkg;

    localparam int unsigned DEPTH       = 4096;
    localparam int unsigned COUNT_WIDTH = 16;

    localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IDX_W     = 12;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned ACC_W     = 40;
    localparam int unsigned OCNT_W    = 16;
    localparam int unsigned DIV_CNT_W = $clog2(ACC_W);

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 56;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] Q_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] Q_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_SET     = 2'd1,
        ACT_CONTRIB = 2'd2,
        ACT_REDUCE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_DIV,
        S_DONE
    } state_t;

endpackage

### design/vma_ram.sv
// ----------------------------------------------------------------------------
// Vector mean accumulator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vma_ram #(
    parameter int unsigned WIDTH   = 40,
    parameter int unsigned DEPTH_P = 4096,
    parameter int unsigned ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH_P];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/vma_div.sv
// ----------------------------------------------------------------------------
// Vector mean accumulator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vma_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [vma_pkg::ACC_W-1:0]           dividend_mag,
    input  logic [vma_pkg::COUNT_WIDTH-1:0]     divisor,
    output logic                                done,
    output logic [vma_pkg::ACC_W-1:0]           quotient_mag
);

    localparam int unsigned CW = vma_pkg::COUNT_WIDTH;
    localparam int unsigned AW = vma_pkg::ACC_W;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [vma_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [AW-1:0]                  quo_reg, quo_next;
    logic [CW:0]                    trial;
    logic                           fits;

    // Quotient bits shift in below the dividend bits as they shift out
    always_comb begin
        trial     = {rem_reg, quo_reg[AW-1]};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend_mag;
        end else if (busy_reg) begin
            rem_next = fits ? CW'(trial - {1'b0, divisor}) : CW'(trial);
            quo_next = {quo_reg[AW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == vma_pkg::DIV_CNT_W'(AW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done         = done_reg;
    assign quotient_mag = quo_reg;

endmodule

### design/vector_mean_accumulator_top.sv
// ----------------------------------------------------------------------------
// Vector mean accumulator
// Element-wise saturating sum and mean of contributed Q16.16 vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transfer per element. s_tdata carries the action,
//   the element index and the value; s_tlast marks the last element of a
//   contributed vector. Every input transfer yields exactly one transfer on
//   m_* with the averaged value (reduce only), the vector count, the enable
//   flag and the divide-by-zero flag.
//   Work per item, set by the read-modify-write of the accumulator RAM and
//   the bit-serial divider: start, set state, an ignored contribution and a
//   reduce that needs no division go straight to output; a contribution
//   that updates the RAM reads, adds and writes back, then outputs; a reduce
//   that divides reads, runs 40 divider steps, writes back, then outputs.
//   Items are worked one at a time; s_tready rises again once the result
//   has moved into the output register.
//   Reset clears the vector count, sets aggregation enabled and empties the
//   output register; the accumulator RAM is not cleared.
//   When the receiver stalls, a finished result holds in the output
//   register; the next item is still taken and waits for that slot.
// ----------------------------------------------------------------------------
module vector_mean_accumulator_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action[1:0], index[13:2], value[45:14], zero fill
    input  logic [vma_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_value[31:0], contribution_count[47:32], aggregating[48],
    // divide_by_zero[49], zero fill
    output logic [vma_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned AW = vma_pkg::ACC_W;
    localparam int unsigned VW = vma_pkg::VAL_W;
    localparam int unsigned CW = vma_pkg::COUNT_WIDTH;

    vma_pkg::state_t state_reg, state_next;

    // Unpacked input fields
    vma_pkg::action_t             in_action;
    logic [vma_pkg::IDX_W-1:0]    in_index;
    logic signed [VW-1:0]         in_value;
    logic                         in_range;
    logic                         s_fire;

    // Item and block state
    vma_pkg::action_t             act_reg, act_next;
    logic [vma_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic signed [VW-1:0]         val_reg, val_next;
    logic                         first_reg, first_next;
    logic                         neg_reg, neg_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         en_reg, en_next;
    logic [VW-1:0]                res_reg, res_next;
    logic                         dz_reg, dz_next;
    logic                         m_valid_reg, m_valid_next;
    logic [VW-1:0]                m_res_reg, m_res_next;
    logic [vma_pkg::OCNT_W-1:0]   m_cnt_reg, m_cnt_next;
    logic                         m_en_reg, m_en_next;
    logic                         m_dz_reg, m_dz_next;

    // Datapath
    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_wdata, ram_rdata;
    logic [vma_pkg::ADDR_W-1:0]   ram_raddr;
    logic signed [AW:0]           sum_wide;
    logic [AW-1:0]                sum_sat;
    logic [AW-1:0]                dividend_mag;
    logic                         div_start, div_done;
    logic [AW-1:0]                quo_mag;
    logic [VW-1:0]                quo_sat;
    logic                         out_free;

    assign in_action = vma_pkg::action_t'(s_tdata[1:0]);
    assign in_index  = s_tdata[13:2];
    assign in_value  = s_tdata[45:14];
    assign in_range  = (32'(in_index) < 32'(vma_pkg::DEPTH));
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Saturating accumulate of the stored entry
    assign sum_wide = $signed({ram_rdata[AW-1], ram_rdata}) + (AW+1)'(val_reg);
    assign sum_sat  = (sum_wide[AW] != sum_wide[AW-1])
                    ? (sum_wide[AW] ? vma_pkg::ACC_MIN : vma_pkg::ACC_MAX)
                    : sum_wide[AW-1:0];

    assign dividend_mag = ram_rdata[AW-1] ? (~ram_rdata + 1'b1) : ram_rdata;

    // Restore sign and clamp the quotient to 32 bits
    always_comb begin
        if (neg_reg) begin
            if (quo_mag > AW'(64'h8000_0000)) begin
                quo_sat = vma_pkg::Q_MIN;
            end else begin
                quo_sat = VW'(~quo_mag + 1'b1);
            end
        end else begin
            if (quo_mag > AW'(64'h7FFF_FFFF)) begin
                quo_sat = vma_pkg::Q_MAX;
            end else begin
                quo_sat = quo_mag[VW-1:0];
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vma_pkg::S_IDLE: begin
                if (s_fire) begin
                    case (in_action)
                        vma_pkg::ACT_CONTRIB: begin
                            state_next = (en_reg && in_range) ? vma_pkg::S_MOD
                                                              : vma_pkg::S_DONE;
                        end
                        vma_pkg::ACT_REDUCE: begin
                            state_next = (count_reg != '0 && in_range) ? vma_pkg::S_MOD
                                                                      : vma_pkg::S_DONE;
                        end
                        default: begin
                            state_next = vma_pkg::S_DONE;
                        end
                    endcase
                end
            end
            vma_pkg::S_MOD: begin
                state_next = (act_reg == vma_pkg::ACT_REDUCE) ? vma_pkg::S_DIV
                                                              : vma_pkg::S_DONE;
            end
            vma_pkg::S_DIV: begin
                if (div_done) begin
                    state_next = vma_pkg::S_DONE;
                end
            end
            vma_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = vma_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = vma_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = sum_sat;
        div_start = 1'b0;
        case (state_reg)
            vma_pkg::S_IDLE: begin
                s_tready = 1'b1;
                ram_re   = s_tvalid;
            end
            vma_pkg::S_MOD: begin
                if (act_reg == vma_pkg::ACT_REDUCE) begin
                    div_start = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = first_reg ? AW'(val_reg) : sum_sat;
                end
            end
            vma_pkg::S_DIV: begin
                ram_we    = div_done;
                ram_wdata = AW'($signed(quo_sat));
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign ram_raddr = vma_pkg::ADDR_W'(in_index);

    // Item capture, block state and output register
    always_comb begin
        act_next     = act_reg;
        addr_next    = addr_reg;
        val_next     = val_reg;
        first_next   = first_reg;
        neg_next     = neg_reg;
        count_next   = count_reg;
        en_next      = en_reg;
        res_next     = res_reg;
        dz_next      = dz_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_cnt_next   = m_cnt_reg;
        m_en_next    = m_en_reg;
        m_dz_next    = m_dz_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            act_next   = in_action;
            addr_next  = vma_pkg::ADDR_W'(in_index);
            val_next   = in_value;
            first_next = (count_reg == '0);
            res_next   = '0;
            dz_next    = (in_action == vma_pkg::ACT_REDUCE) && (count_reg == '0);
            case (in_action)
                vma_pkg::ACT_START: begin
                    count_next = '0;
                    en_next    = 1'b1;
                end
                vma_pkg::ACT_SET: begin
                    en_next = (in_value != '0);
                end
                vma_pkg::ACT_CONTRIB: begin
                    if (en_reg && s_tlast && count_reg != vma_pkg::COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end

        if (state_reg == vma_pkg::S_MOD) begin
            neg_next = ram_rdata[AW-1];
        end

        if (state_reg == vma_pkg::S_DIV && div_done) begin
            res_next = quo_sat;
        end

        if (state_reg == vma_pkg::S_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_res_next   = res_reg;
            m_cnt_next   = vma_pkg::OCNT_W'(count_reg);
            m_en_next    = en_reg;
            m_dz_next    = dz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vma_pkg::S_IDLE;
            count_reg   <= '0;
            en_reg      <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            en_reg      <= en_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        addr_reg  <= addr_next;
        val_reg   <= val_next;
        first_reg <= first_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
        dz_reg    <= dz_next;
        m_res_reg <= m_res_next;
        m_cnt_reg <= m_cnt_next;
        m_en_reg  <= m_en_next;
        m_dz_reg  <= m_dz_next;
    end

    vma_ram #(
        .WIDTH   (AW),
        .DEPTH_P (vma_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vma_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (div_start),
        .dividend_mag (dividend_mag),
        .divisor      (count_reg),
        .done         (div_done),
        .quotient_mag (quo_mag)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_dz_reg, m_en_reg, m_cnt_reg, m_res_reg};

    // A division result only arrives while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == vma_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    // The count only drops through a start, which is taken in idle
    a_count_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != vma_pkg::S_IDLE) |=> (count_reg >= $past(count_reg)))
        else $error("vector count dropped while an item was in flight");

    // A new result is loaded only from the done state
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == vma_pkg::S_DONE))
        else $error("output loaded outside the done state");

    // A divide-by-zero result carries a zero value
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_dz_reg) |-> (m_res_reg == '0))
        else $error("divide-by-zero result with nonzero value");

    // The RAM is never read and written in the same cycle
    a_ram_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("RAM read and write overlap");

endmodule
